// ===== sv/i2c_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c_seq_pkg
// Codes, status values and defaults for the I2C event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_seq_pkg;

  localparam int TX_DEPTH_DEF = 32;
  localparam logic [7:0] MAX_TRIES_RST = 8'd3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_NACK    = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_RELEASE = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_BUSY      = 3'd1,
    RES_BAD_PARAM = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_ABORTED   = 3'd4,
    RES_REJECTED  = 3'd5,
    RES_UNKNOWN   = 3'd6
  } result_t;

  typedef enum logic [2:0] {
    NTC_NONE  = 3'd0,
    NTC_START = 3'd1,
    NTC_BCAST = 3'd2,
    NTC_DATA  = 3'd3,
    NTC_END   = 3'd4,
    NTC_MORE  = 3'd5
  } notice_t;

  localparam logic [1:0] REG_SLAVE_MODE = 2'd0;
  localparam logic [1:0] REG_RX_PRESENT = 2'd1;
  localparam logic [1:0] REG_TX_PRESENT = 2'd2;
  localparam logic [1:0] REG_MAX_TRIES  = 2'd3;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
  localparam logic [7:0] ST_SR_START    = 8'h60;
  localparam logic [7:0] ST_SR_BCAST    = 8'h70;
  localparam logic [7:0] ST_SR_DATA     = 8'h80;
  localparam logic [7:0] ST_SR_BC_DATA  = 8'h90;
  localparam logic [7:0] ST_SR_STOP     = 8'hA0;
  localparam logic [7:0] ST_ST_START    = 8'hA8;
  localparam logic [7:0] ST_ST_DATA     = 8'hB8;
  localparam logic [7:0] ST_ST_NACK     = 8'hC0;
  localparam logic [7:0] ST_ST_LAST     = 8'hC8;

endpackage

`default_nettype wire

// ===== sv/i2c_master_slave_event_sequencer.sv =====
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the single result register stalls the input
// only while a finished word waits downstream.
// Reset (synchronous): clears busy flag, counters, config and output valid;
// the transmit store is undefined until loaded.
// ----------------------------------------------------------------------------
// i2c_master_slave_event_sequencer
// Decides bus actions, transmit bytes, completions and slave notices for an
// I2C controller from load, start and bus status words.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_slave_event_sequencer #(
  parameter int TX_DEPTH = i2c_seq_pkg::TX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [4:0]  slot,
  input  wire logic [6:0]  dest_address,
  input  wire logic [7:0]  length,
  input  wire logic        read_not_write,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  bus_status,
  input  wire logic        app_accepts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  bus_action,
  output logic             drive_valid,
  output logic      [7:0]  drive_byte,
  output logic             rx_valid,
  output logic      [7:0]  rx_byte,
  output logic             done_res,
  output logic      [2:0]  result_code,
  output logic             busy_res,
  output logic      [2:0]  slave_notice,
  output logic             notice_to_transmitter
);
  import i2c_seq_pkg::*;

  localparam int IdxW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic            slave_mode_enabled;
  logic            receiver_present;
  logic            transmitter_present;
  logic [7:0]      max_tries;
  logic            cfg_we;

  logic [7:0]      tx_store [TX_DEPTH];
  logic [7:0]      rd_q;

  logic            busy_flag, busy_flag_next;
  logic [7:0]      address_byte, address_byte_next;
  logic [7:0]      byte_count, byte_count_next;
  logic [7:0]      byte_position, byte_position_next;
  logic [7:0]      tries_remaining, tries_remaining_next;

  logic            accept;
  logic            load_we;
  logic [IdxW-1:0] waddr, raddr;
  logic [7:0]      st;
  logic [7:0]      pos_bump;
  logic            pos_in_store;

  logic [2:0]      bus_action_next;
  logic            drive_valid_next;
  logic [7:0]      drive_byte_next;
  logic            rx_valid_next;
  logic [7:0]      rx_byte_next;
  logic            done_res_next;
  logic [2:0]      result_code_next;
  logic [2:0]      slave_notice_next;
  logic            notice_to_transmitter_next;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_SLAVE_MODE: prdata = {31'd0, slave_mode_enabled};
      REG_RX_PRESENT: prdata = {31'd0, receiver_present};
      REG_TX_PRESENT: prdata = {31'd0, transmitter_present};
      REG_MAX_TRIES:  prdata = {24'd0, max_tries};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_mode_enabled  <= 1'b0;
      receiver_present    <= 1'b0;
      transmitter_present <= 1'b0;
      max_tries           <= MAX_TRIES_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SLAVE_MODE: slave_mode_enabled  <= pwdata[0];
        REG_RX_PRESENT: receiver_present    <= pwdata[0];
        REG_TX_PRESENT: transmitter_present <= pwdata[0];
        REG_MAX_TRIES:  max_tries           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign st           = {bus_status[7:3], 3'b000};
  assign pos_bump     = (byte_position != 8'hFF) ? byte_position + 8'd1 : byte_position;
  assign pos_in_store = 9'(byte_position) < 9'(TX_DEPTH);

  always_comb begin
    busy_flag_next             = busy_flag;
    address_byte_next          = address_byte;
    byte_count_next            = byte_count;
    byte_position_next         = byte_position;
    tries_remaining_next       = tries_remaining;
    bus_action_next            = ACT_NONE;
    drive_valid_next           = 1'b0;
    drive_byte_next            = 8'd0;
    rx_valid_next              = 1'b0;
    rx_byte_next               = 8'd0;
    done_res_next              = 1'b0;
    result_code_next           = RES_OK;
    slave_notice_next          = NTC_NONE;
    notice_to_transmitter_next = 1'b0;
    load_we                    = 1'b0;

    if (accept) begin
      unique case (command)
        CMD_LOAD: begin
          load_we = 9'(slot) < 9'(TX_DEPTH);
        end
        CMD_START: begin
          if (busy_flag) begin
            done_res_next    = 1'b1;
            result_code_next = RES_BUSY;
          end else if (length == 8'd0 ||
                       (read_not_write ? (dest_address == 7'd0)
                                       : (9'(length) > 9'(TX_DEPTH)))) begin
            done_res_next    = 1'b1;
            result_code_next = RES_BAD_PARAM;
          end else begin
            busy_flag_next       = 1'b1;
            address_byte_next    = {dest_address, read_not_write};
            byte_count_next      = length;
            byte_position_next   = 8'd0;
            tries_remaining_next = max_tries;
            bus_action_next      = ACT_START;
          end
        end
        CMD_STATUS: begin
          unique case (st)
            ST_START, ST_RESTART: begin
              drive_valid_next = 1'b1;
              drive_byte_next  = address_byte;
              bus_action_next  = ACT_ACK;
            end
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              if (byte_position < byte_count) begin
                drive_valid_next   = 1'b1;
                drive_byte_next    = pos_in_store ? rd_q : 8'd0;
                byte_position_next = pos_bump;
                bus_action_next    = ACT_NACK;
              end else begin
                bus_action_next  = ACT_STOP;
                busy_flag_next   = 1'b0;
                done_res_next    = 1'b1;
                result_code_next = RES_OK;
              end
            end
            ST_SLA_R_ACK: begin
              bus_action_next = (byte_count > 8'd1) ? ACT_ACK : ACT_NACK;
            end
            ST_DATA_R_ACK: begin
              rx_valid_next      = 1'b1;
              rx_byte_next       = data_byte;
              byte_position_next = pos_bump;
              bus_action_next    = (byte_count != 8'd0 && pos_bump < byte_count - 8'd1)
                                   ? ACT_ACK : ACT_NACK;
            end
            ST_ARB_LOST: begin
              bus_action_next = ACT_START;
            end
            ST_SLA_W_NACK, ST_SLA_R_NACK: begin
              if (tries_remaining > 8'd1) begin
                tries_remaining_next = tries_remaining - 8'd1;
                bus_action_next      = ACT_START;
              end else begin
                tries_remaining_next = 8'd0;
                bus_action_next      = ACT_STOP;
                busy_flag_next       = 1'b0;
                done_res_next        = 1'b1;
                result_code_next     = RES_NOT_FOUND;
              end
            end
            ST_DATA_R_NACK: begin
              rx_valid_next      = 1'b1;
              rx_byte_next       = data_byte;
              byte_position_next = pos_bump;
              bus_action_next    = ACT_STOP;
              busy_flag_next     = 1'b0;
              done_res_next      = 1'b1;
              result_code_next   = RES_OK;
            end
            ST_DATA_W_NACK: begin
              bus_action_next  = ACT_STOP;
              busy_flag_next   = 1'b0;
              done_res_next    = 1'b1;
              result_code_next = (byte_position > 8'd1) ? RES_ABORTED : RES_REJECTED;
            end
            ST_SR_START, ST_SR_BCAST: begin
              if (receiver_present) begin
                slave_notice_next = (st == ST_SR_START) ? NTC_START : NTC_BCAST;
                bus_action_next   = app_accepts ? ACT_ACK : ACT_NACK;
              end
            end
            ST_SR_DATA, ST_SR_BC_DATA: begin
              if (receiver_present) begin
                slave_notice_next = NTC_DATA;
              end
              bus_action_next = ACT_ACK;
            end
            ST_ST_START, ST_ST_DATA: begin
              if (transmitter_present) begin
                slave_notice_next          = (st == ST_ST_START) ? NTC_START : NTC_DATA;
                notice_to_transmitter_next = 1'b1;
                bus_action_next            = app_accepts ? ACT_ACK : ACT_NACK;
              end
            end
            ST_SR_STOP: begin
              if (receiver_present) begin
                slave_notice_next = NTC_END;
              end
              bus_action_next = ACT_RELEASE;
              busy_flag_next  = 1'b0;
            end
            ST_ST_NACK, ST_ST_LAST: begin
              if (transmitter_present) begin
                slave_notice_next          = (st == ST_ST_NACK) ? NTC_END : NTC_MORE;
                notice_to_transmitter_next = 1'b1;
              end
              bus_action_next = ACT_RELEASE;
              busy_flag_next  = 1'b0;
            end
            default: begin
              bus_action_next  = ACT_RELEASE;
              busy_flag_next   = 1'b0;
              done_res_next    = 1'b1;
              result_code_next = RES_UNKNOWN;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // transmit store: prefetch the slot at the next byte position
  assign waddr = IdxW'(slot);
  assign raddr = IdxW'(byte_position_next);

  always_ff @(posedge clk) begin
    if (load_we) begin
      tx_store[waddr] <= data_byte;
    end
    if (load_we && waddr == raddr) begin
      rd_q <= data_byte;
    end else begin
      rd_q <= tx_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag       <= 1'b0;
      address_byte    <= 8'd0;
      byte_count      <= 8'd0;
      byte_position   <= 8'd0;
      tries_remaining <= 8'd0;
      out_valid       <= 1'b0;
    end else begin
      busy_flag       <= busy_flag_next;
      address_byte    <= address_byte_next;
      byte_count      <= byte_count_next;
      byte_position   <= byte_position_next;
      tries_remaining <= tries_remaining_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bus_action            <= bus_action_next;
      drive_valid           <= drive_valid_next;
      drive_byte            <= drive_byte_next;
      rx_valid              <= rx_valid_next;
      rx_byte               <= rx_byte_next;
      done_res              <= done_res_next;
      result_code           <= result_code_next;
      busy_res              <= busy_flag_next;
      slave_notice          <= slave_notice_next;
      notice_to_transmitter <= notice_to_transmitter_next;
    end
  end

endmodule

`default_nettype wire
